>>> hw/rtl/bht_pkg.sv
// shared types, constants and record helpers for the bucketed hash table
package bht_pkg;

  // default geometry
  localparam int unsigned BhtBuckets  = 256;
  localparam int unsigned BhtSlots    = 4;
  localparam int unsigned BhtOverflow = 64;

  // fixed field widths
  localparam int unsigned KeyW    = 64;
  localparam int unsigned HandleW = 31;
  localparam int unsigned RecW    = HandleW + 2;

  typedef logic [RecW-1:0] rec_t;

  // request kinds
  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_BADKEY   = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // flag actions
  typedef enum logic [1:0] {
    ACT_KEEP  = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_START = 2'd2,
    ACT_SPARE = 2'd3
  } action_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_EVAL,
    S_ACT,
    S_DONE
  } state_e;

  // apply handle and flag actions to a record
  function automatic rec_t apply_actions(rec_t rec, logic [HandleW-1:0] h,
                                         logic [1:0] ba, logic [1:0] sa);
    rec_t r;
    r = rec;
    if (h != '0) r[HandleW-1:0] = h;
    if (ba == ACT_STOP) r[HandleW] = 1'b0;
    else if (ba == ACT_START) r[HandleW] = 1'b1;
    if (sa == ACT_STOP) r[HandleW+1] = 1'b0;
    else if (sa == ACT_START) r[HandleW+1] = 1'b1;
    return r;
  endfunction

endpackage

>>> hw/rtl/bucketed_hash_table_top.sv
// Bucketed hash table: one request per word, one result word per request.
// The key modulo BUCKETS picks a home block of SLOTS slots; blocks chain to
// overflow blocks drawn in order from a pool of OVERFLOW_BLOCKS. Each chain
// block takes a registered row read of keys, records and link, then an
// evaluate step; a request then takes an action step and a step to post the
// result. An invalid key skips the walk and goes straight to the result step.
// When BUCKETS is not a power of two the bucket index is found from the
// key's four 16-bit digits by reciprocal multiplication on one shared
// multiplier, each digit passing a reciprocal multiply, a multiply back by
// BUCKETS and a remainder correction. After reset a clearing pass over all
// BUCKETS + OVERFLOW_BLOCKS rows wipes the key and link stores; no request
// is taken until it ends. One request is worked on at a time; the next may
// be taken while the previous result still waits.
module bucketed_hash_table_top
  import bht_pkg::*;
#(
  parameter int unsigned BUCKETS         = BhtBuckets,
  parameter int unsigned SLOTS           = BhtSlots,
  parameter int unsigned OVERFLOW_BLOCKS = BhtOverflow
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [KeyW-1:0]    key_i,
  input  logic [HandleW-1:0] new_handle_i,
  input  logic [1:0]         balance_action_i,
  input  logic [1:0]         stats_action_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [HandleW-1:0] handle_o,
  output logic               balance_on_o,
  output logic               stats_on_o
);

  localparam int unsigned ROWS   = BUCKETS + OVERFLOW_BLOCKS;
  localparam int unsigned BLK_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned BKT_W  = $clog2(BUCKETS);
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LINK_W = (OVERFLOW_BLOCKS > 0) ? $clog2(OVERFLOW_BLOCKS + 1) : 1;
  localparam bit          POW2   = ((1 << BKT_W) == BUCKETS);
  localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / BUCKETS);
  localparam logic [31:0] BKT_C  = 32'(BUCKETS);

  typedef logic [KeyW-1:0] key_t;

  // storage
  key_t              key_mem  [ROWS][SLOTS];
  rec_t              rec_mem  [ROWS][SLOTS];
  logic [LINK_W-1:0] link_mem [ROWS];

  key_t              key_row_q [SLOTS];
  rec_t              rec_row_q [SLOTS];
  logic [LINK_W-1:0] link_q;

  state_e state_q, state_d;

  // request and walk registers
  logic [1:0]         kind_q;
  key_t               key_q;
  logic [HandleW-1:0] h_q;
  logic [1:0]         ba_q, sa_q;
  logic [BLK_W-1:0]   cur_q, cur_d;
  logic [BKT_W-1:0]   rem_q, rem_d;
  logic [1:0]         dig_q, dig_d;
  logic [1:0]         ph_q, ph_d;
  logic [31:0]        hx_q, hx_d;
  logic [63:0]        prod_q, prod_d;
  logic [BLK_W-1:0]   clr_q, clr_d;
  logic               hit_q, hit_d;
  logic [SLOT_W-1:0]  hit_s_q, hit_s_d;
  logic               free_q, free_d;
  logic [BLK_W-1:0]   free_blk_q, free_blk_d;
  logic [SLOT_W-1:0]  free_s_q, free_s_d;
  logic [LINK_W-1:0]  used_q, used_d;

  // pending result and output register
  logic [1:0]         res_st_q, res_st_d;
  rec_t               res_rec_q, res_rec_d;
  logic               out_valid_q;
  logic [1:0]         status_q;
  rec_t               out_rec_q;

  // memory write controls
  logic               kw_en, rw_en, lw_en;
  logic [BLK_W-1:0]   w_blk;
  logic [SLOT_W-1:0]  w_slot;
  key_t               kw_val;
  rec_t               rw_val;
  logic [LINK_W-1:0]  lw_val;

  // row evaluation
  logic               stop_f, stop_hit, row_free;
  logic [SLOT_W-1:0]  stop_s, row_free_s;
  logic               link_ok;
  logic [BLK_W-1:0]   next_blk;
  logic [31:0]        hx_cat, hx_rem, mul_a, mul_b;
  logic [63:0]        mul_p;
  logic               accept, out_free, key_bad;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign key_bad  = (key_i == '0) || (key_i == '1);

  // priority scan of the current row
  always_comb begin
    stop_f     = 1'b0;
    stop_hit   = 1'b0;
    stop_s     = '0;
    row_free   = 1'b0;
    row_free_s = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!stop_f && (key_row_q[s] == '0 || key_row_q[s] == key_q)) begin
        stop_f   = 1'b1;
        stop_hit = (key_row_q[s] == key_q);
        stop_s   = SLOT_W'(s);
      end
      if (!row_free && (key_row_q[s] == '0 || key_row_q[s] == '1)) begin
        row_free   = 1'b1;
        row_free_s = SLOT_W'(s);
      end
    end
  end

  // chain link decode
  always_comb begin
    link_ok  = (link_q != '0) && ((LINK_W + 1)'(link_q - 1'b1) < (LINK_W + 1)'(OVERFLOW_BLOCKS));
    next_blk = BLK_W'(BUCKETS) + BLK_W'(link_q - 1'b1);
  end

  // shared multiplier and remainder correction for one key digit
  always_comb begin
    hx_cat = (32'(rem_q) << 16) | 32'(key_q[{~dig_q, 4'b0000} +: 16]);
    mul_a  = hx_cat;
    mul_b  = RECIP;
    if (ph_q == 2'd1) begin
      mul_a = prod_q[63:32];
      mul_b = BKT_C;
    end
    mul_p  = {32'b0, mul_a} * {32'b0, mul_b};
    hx_rem = hx_q - prod_q[31:0];
    if (hx_rem >= BKT_C) hx_rem = hx_rem - BKT_C;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == BLK_W'(ROWS - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (key_bad) state_d = S_DONE;
          else if (POW2) state_d = S_READ;
          else state_d = S_HASH;
        end
      end
      S_HASH: if (ph_q == 2'd2 && dig_q == 2'd3) state_d = S_READ;
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        if (stop_f || !link_ok) state_d = S_ACT;
        else state_d = S_READ;
      end
      S_ACT:  state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory write controls
  always_comb begin
    cur_d      = cur_q;
    rem_d      = rem_q;
    dig_d      = dig_q;
    ph_d       = ph_q;
    hx_d       = hx_q;
    prod_d     = prod_q;
    clr_d      = clr_q;
    hit_d      = hit_q;
    hit_s_d    = hit_s_q;
    free_d     = free_q;
    free_blk_d = free_blk_q;
    free_s_d   = free_s_q;
    used_d     = used_q;
    res_st_d   = res_st_q;
    res_rec_d  = res_rec_q;
    kw_en      = 1'b0;
    rw_en      = 1'b0;
    lw_en      = 1'b0;
    w_blk      = cur_q;
    w_slot     = hit_s_q;
    kw_val     = key_q;
    rw_val     = '0;
    lw_val     = used_q + 1'b1;
    unique case (state_q)
      S_CLEAR: clr_d = clr_q + 1'b1;
      S_IDLE: begin
        cur_d   = BLK_W'(key_i[BKT_W-1:0]);
        rem_d   = '0;
        dig_d   = '0;
        ph_d    = '0;
        hit_d   = 1'b0;
        free_d  = 1'b0;
        res_st_d  = ST_BADKEY;
        res_rec_d = '0;
      end
      S_HASH: begin
        case (ph_q)
          2'd0: begin
            hx_d   = hx_cat;
            prod_d = mul_p;
            ph_d   = 2'd1;
          end
          2'd1: begin
            prod_d = mul_p;
            ph_d   = 2'd2;
          end
          default: begin
            rem_d = hx_rem[BKT_W-1:0];
            cur_d = BLK_W'(hx_rem[BKT_W-1:0]);
            dig_d = dig_q + 1'b1;
            ph_d  = 2'd0;
          end
        endcase
      end
      S_READ: ;
      S_EVAL: begin
        if (!free_q && row_free) begin
          free_d     = 1'b1;
          free_blk_d = cur_q;
          free_s_d   = row_free_s;
        end
        if (stop_f) begin
          hit_d   = stop_hit;
          hit_s_d = stop_s;
        end else if (link_ok) begin
          cur_d = next_blk;
        end
      end
      S_ACT: begin
        res_st_d  = ST_OK;
        res_rec_d = '0;
        case (kind_q)
          KIND_DELETE: begin
            if (hit_q) begin
              kw_en  = 1'b1;
              rw_en  = 1'b1;
              kw_val = '1;
            end else begin
              res_st_d = ST_NOTFOUND;
            end
          end
          KIND_UPDATE: begin
            if (hit_q) begin
              rw_en     = 1'b1;
              rw_val    = apply_actions(rec_row_q[hit_s_q], h_q, ba_q, sa_q);
              res_rec_d = rw_val;
            end else if (free_q) begin
              kw_en     = 1'b1;
              rw_en     = 1'b1;
              w_blk     = free_blk_q;
              w_slot    = free_s_q;
              rw_val    = apply_actions('0, h_q, ba_q, sa_q);
              res_rec_d = rw_val;
            end else if ((LINK_W + 1)'(used_q) >= (LINK_W + 1)'(OVERFLOW_BLOCKS)) begin
              res_st_d = ST_FULL;
            end else begin
              lw_en     = 1'b1;
              kw_en     = 1'b1;
              rw_en     = 1'b1;
              used_d    = used_q + 1'b1;
              rw_val    = apply_actions('0, h_q, ba_q, sa_q);
              res_rec_d = rw_val;
            end
          end
          default: begin
            if (hit_q) res_rec_d = rec_row_q[hit_s_q];
            else res_st_d = ST_NOTFOUND;
          end
        endcase
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // key store: clearing pass, then single-slot writes
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      for (int s = 0; s < SLOTS; s++) key_mem[clr_q][s] <= '0;
    end else if (kw_en) begin
      if (lw_en) key_mem[BLK_W'(BUCKETS) + BLK_W'(used_q)][0] <= kw_val;
      else key_mem[w_blk][w_slot] <= kw_val;
    end
    if (state_q == S_READ) key_row_q <= key_mem[cur_q];
  end

  // record store
  always_ff @(posedge clk_i) begin
    if (rw_en) begin
      if (lw_en) rec_mem[BLK_W'(BUCKETS) + BLK_W'(used_q)][0] <= rw_val;
      else rec_mem[w_blk][w_slot] <= rw_val;
    end
    if (state_q == S_READ) rec_row_q <= rec_mem[cur_q];
  end

  // link store
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) link_mem[clr_q] <= '0;
    else if (lw_en) link_mem[cur_q] <= lw_val;
    if (state_q == S_READ) link_q <= link_mem[cur_q];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      used_q  <= used_d;
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // request, walk and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      key_q  <= key_i;
      h_q    <= new_handle_i;
      ba_q   <= balance_action_i;
      sa_q   <= stats_action_i;
    end
    cur_q      <= cur_d;
    rem_q      <= rem_d;
    dig_q      <= dig_d;
    ph_q       <= ph_d;
    hx_q       <= hx_d;
    prod_q     <= prod_d;
    hit_q      <= hit_d;
    hit_s_q    <= hit_s_d;
    free_q     <= free_d;
    free_blk_q <= free_blk_d;
    free_s_q   <= free_s_d;
    res_st_q   <= res_st_d;
    res_rec_q  <= res_rec_d;
    if (state_q == S_DONE && out_free) begin
      status_q  <= res_st_q;
      out_rec_q <= res_rec_q;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign handle_o     = out_rec_q[HandleW-1:0];
  assign balance_on_o = out_rec_q[HandleW];
  assign stats_on_o   = out_rec_q[HandleW+1];

  // checks
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LINK_W + 1)'(used_q) <= (LINK_W + 1)'(OVERFLOW_BLOCKS))
    else $error("overflow pool count out of range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != S_IDLE)
    else $error("accepted word did not start a request");

  a_write_in_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kw_en || lw_en |-> state_q == S_ACT)
    else $error("store written outside the action cycle");

  a_badkey_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_BADKEY |-> handle_o == '0 && !balance_on_o && !stats_on_o)
    else $error("invalid key result carries a record");

endmodule

>>> bench/tb.sv
// self-checking testbench for the bucketed hash table top level
`timescale 1ns / 100ps

module tb
  import bht_pkg::*;
;

  localparam int unsigned NBUCK  = BhtBuckets;
  localparam int unsigned NSLOT  = BhtSlots;
  localparam int unsigned NPOOL  = BhtOverflow;
  localparam int unsigned NBLK   = NBUCK + NPOOL;
  localparam logic [KeyW-1:0] TOMBSTONE = '1;

  // result word as predicted or observed
  typedef struct packed {
    status_e            status;
    logic [HandleW-1:0] handle;
    logic               bal;
    logic               stat;
  } answer_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         kind_i = '0;
  logic [KeyW-1:0]    key_i = '0;
  logic [HandleW-1:0] new_handle_i = '0;
  logic [1:0]         balance_action_i = '0;
  logic [1:0]         stats_action_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [HandleW-1:0] handle_o;
  logic               balance_on_o;
  logic               stats_on_o;

  bucketed_hash_table_top u_top (.*);

  always #4 clk_i = ~clk_i;

  // shadow table
  logic [KeyW-1:0] shadow_keys [NBLK*NSLOT];
  rec_t            shadow_recs [NBLK*NSLOT];
  int unsigned     shadow_links[NBLK];
  int unsigned     pool_taken;

  answer_t pending_answers[$];
  int      mismatches;
  int      send_idle_pct;
  int      recv_stall_pct;
  logic [KeyW-1:0] live_keys[$];

  // apply flag and handle actions to a record
  function automatic rec_t modify_record(rec_t r, logic [HandleW-1:0] h,
                                         logic [1:0] ba, logic [1:0] sa);
    rec_t n;
    n = r;
    if (h != '0) n[HandleW-1:0] = h;
    if (ba == ACT_STOP) n[HandleW] = 1'b0;
    else if (ba == ACT_START) n[HandleW] = 1'b1;
    if (sa == ACT_STOP) n[HandleW+1] = 1'b0;
    else if (sa == ACT_START) n[HandleW+1] = 1'b1;
    return n;
  endfunction

  function automatic int chain_next(int blk);
    int unsigned l;
    l = shadow_links[blk];
    if (l == 0 || l - 1 >= NPOOL) return -1;
    return NBUCK + l - 1;
  endfunction

  function automatic int locate_key(logic [KeyW-1:0] k);
    int blk;
    blk = int'(k % NBUCK);
    for (int st = 0; st < NBLK && blk >= 0; st++) begin
      for (int s = 0; s < NSLOT; s++) begin
        if (shadow_keys[blk*NSLOT+s] == '0) return -1;
        if (shadow_keys[blk*NSLOT+s] == k) return blk*NSLOT + s;
      end
      blk = chain_next(blk);
    end
    return -1;
  endfunction

  function automatic answer_t from_record(rec_t r);
    answer_t a;
    a.status = ST_OK;
    a.handle = r[HandleW-1:0];
    a.bal    = r[HandleW];
    a.stat   = r[HandleW+1];
    return a;
  endfunction

  // predict one request and update the shadow table
  function automatic answer_t predict_table(logic [1:0] kind, logic [KeyW-1:0] k,
                                            logic [HandleW-1:0] h,
                                            logic [1:0] ba, logic [1:0] sa);
    answer_t a;
    int idx, blk, last, freeidx, nb;
    a = '0;
    a.status = ST_OK;
    if (k == '0 || k == TOMBSTONE) begin
      a.status = ST_BADKEY;
      return a;
    end
    idx = locate_key(k);
    if (kind == KIND_DELETE) begin
      if (idx < 0) a.status = ST_NOTFOUND;
      else begin
        shadow_keys[idx] = TOMBSTONE;
        shadow_recs[idx] = '0;
      end
      return a;
    end
    if (kind != KIND_UPDATE) begin
      if (idx < 0) a.status = ST_NOTFOUND;
      else a = from_record(shadow_recs[idx]);
      return a;
    end
    if (idx >= 0) begin
      shadow_recs[idx] = modify_record(shadow_recs[idx], h, ba, sa);
      return from_record(shadow_recs[idx]);
    end
    blk = int'(k % NBUCK);
    last = blk;
    freeidx = -1;
    for (int st = 0; st < NBLK && blk >= 0 && freeidx < 0; st++) begin
      for (int s = 0; s < NSLOT; s++) begin
        if (freeidx < 0 && (shadow_keys[blk*NSLOT+s] == '0 ||
                            shadow_keys[blk*NSLOT+s] == TOMBSTONE))
          freeidx = blk*NSLOT + s;
      end
      last = blk;
      blk = chain_next(blk);
    end
    if (freeidx < 0) begin
      if (pool_taken >= NPOOL) begin
        a.status = ST_FULL;
        return a;
      end
      nb = NBUCK + pool_taken;
      pool_taken++;
      shadow_links[last] = pool_taken;
      freeidx = nb * NSLOT;
    end
    shadow_recs[freeidx] = modify_record('0, h, ba, sa);
    shadow_keys[freeidx] = k;
    live_keys.push_back(k);
    return from_record(shadow_recs[freeidx]);
  endfunction

  // send one request word, with random idling before it
  task automatic send_request(logic [1:0] kind, logic [KeyW-1:0] k,
                              logic [HandleW-1:0] h, logic [1:0] ba, logic [1:0] sa);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    kind_i           <= kind;
    key_i            <= k;
    new_handle_i     <= h;
    balance_action_i <= ba;
    stats_action_i   <= sa;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_answers.push_back(predict_table(kind, k, h, ba, sa));
  endtask

  // receiver stall and result comparison
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word status %0d", status_o);
        end else begin
          want = pending_answers.pop_front();
          if (status_o !== want.status || handle_o !== want.handle ||
              balance_on_o !== want.bal || stats_on_o !== want.stat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st %0d h %0h b %0b s %0b, got st %0d h %0h b %0b s %0b",
                       want.status, want.handle, want.bal, want.stat,
                       status_o, handle_o, balance_on_o, stats_on_o);
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // drop the request word and wait for every result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [KeyW-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // key in a given bucket, never invalid
  function automatic logic [KeyW-1:0] bucket_key(int b);
    logic [KeyW-1:0] k;
    k = random_key();
    k = (k & ~(KeyW'(NBUCK - 1))) | KeyW'(b);
    if (k == '0 || k == TOMBSTONE) k = KeyW'(NBUCK + b);
    return k;
  endfunction

  // invalid keys, extremes and odd codes
  task automatic test_directed();
    send_request(KIND_LOOKUP, '0, '0, ACT_KEEP, ACT_KEEP);
    send_request(KIND_UPDATE, TOMBSTONE, '1, ACT_START, ACT_START);
    send_request(KIND_DELETE, '0, '0, ACT_KEEP, ACT_KEEP);
    send_request(KIND_LOOKUP, 64'h1, '0, ACT_KEEP, ACT_KEEP);
    send_request(KIND_DELETE, 64'h1, '0, ACT_KEEP, ACT_KEEP);
    send_request(KIND_UPDATE, 64'h1, '1, ACT_START, ACT_START);
    send_request(KIND_UPDATE, 64'h1, '0, ACT_SPARE, ACT_SPARE);
    send_request(KIND_UPDATE, 64'h1, 31'h1, ACT_STOP, ACT_KEEP);
    send_request(KIND_SPARE, 64'h1, '0, ACT_KEEP, ACT_KEEP);
    send_request(KIND_UPDATE, 64'hFFFF_FFFF_FFFF_FFFE, 31'h2AAA_AAAA, ACT_KEEP, ACT_STOP);
    send_request(KIND_UPDATE, 64'h8000_0000_0000_0000, 31'h5555_5555, ACT_START, ACT_KEEP);
    send_request(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, '0, ACT_KEEP, ACT_KEEP);
    send_request(KIND_DELETE, 64'h1, '0, ACT_KEEP, ACT_KEEP);
    send_request(KIND_LOOKUP, 64'h1, '0, ACT_KEEP, ACT_KEEP);
    // tombstone reuse
    send_request(KIND_UPDATE, 64'h101, 31'h7, ACT_START, ACT_START);
    send_request(KIND_LOOKUP, 64'h101, '0, ACT_KEEP, ACT_KEEP);
  endtask

  // long chains in a few buckets, then pool exhaustion
  task automatic test_chains(int n);
    logic [KeyW-1:0] k;
    for (int i = 0; i < n; i++) begin
      k = bucket_key($urandom_range(7));
      send_request(KIND_UPDATE, k, HandleW'($urandom), 2'($urandom_range(3)),
                   2'($urandom_range(3)));
      if ($urandom_range(3) == 0)
        send_request(KIND_LOOKUP, k, HandleW'($urandom), 2'($urandom_range(3)),
                     2'($urandom_range(3)));
    end
  endtask

  // mixed random traffic on known, fresh and invalid keys
  task automatic test_random(int n);
    logic [KeyW-1:0] k;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 3) k = ($urandom_range(1) != 0) ? '0 : TOMBSTONE;
      else if (r < 60 && live_keys.size() > 0)
        k = live_keys[$urandom_range(live_keys.size() - 1)];
      else if (r < 80) k = bucket_key($urandom_range(NBUCK - 1));
      else k = random_key();
      send_request(2'($urandom_range(3)), k,
                   ($urandom_range(3) == 0) ? '0 : HandleW'($urandom),
                   2'($urandom_range(3)), 2'($urandom_range(3)));
    end
  endtask

  initial begin
    for (int i = 0; i < NBLK*NSLOT; i++) begin
      shadow_keys[i] = '0;
      shadow_recs[i] = '0;
    end
    for (int i = 0; i < NBLK; i++) shadow_links[i] = 0;
    pool_taken = 0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    send_idle_pct = 70;
    test_random(300);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 70;
    test_chains(350);
    send_idle_pct = 24;
    recv_stall_pct = 24;
    test_random(500);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(400);

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/bht_pkg.sv
hw/rtl/bucketed_hash_table_top.sv
bench/tb.sv
